@@ rtl/core/chroma_mask_blob_centroid_top_defines.svh @@
// Assertion macros shared by the chroma mask blob centroid RTL.
`ifndef CHROMA_MASK_BLOB_CENTROID_TOP_DEFINES_SVH
`define CHROMA_MASK_BLOB_CENTROID_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CMBC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmbc: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CMBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmbc: next-cycle check failed");

`endif

@@ rtl/core/cmbc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the chroma mask blob centroid block.
package cmbc_pkg;

   localparam int MAX_COLS   = 2048;
   localparam int MAX_ROWS   = 2048;

   localparam int COLOR_W    = 8;
   localparam int POS_W      = 11;
   localparam int POS_CMP_W  = 14;
   localparam int COUNT_W    = 23;
   localparam int SUM_W      = 34;
   localparam int S_W        = 10;
   localparam int LHS_W      = 18;
   localparam int PROD_W     = 20;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = 3;
   localparam int QUEUE_LVL_W = 4;

   localparam int DIV_W      = 35;
   localparam int REM_W      = 24;
   localparam int DIV_CNT_W  = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_RED_THRESHOLD        = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_THRESHOLD      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS_THRESHOLD = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PIXELS           = 8'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX        = 23'h7FFFFF;
   localparam logic [COUNT_W-1:0] MIN_PIXELS_RESET = 23'd50;
   localparam logic [COLOR_W-1:0] THRESHOLD_TOP    = 8'hFF;

   typedef struct packed {
      logic [COLOR_W-1:0] red_thr;
      logic [COLOR_W-1:0] green_thr;
      logic [COLOR_W-1:0] bright_thr;
      logic [COUNT_W-1:0] min_pixels;
   } cfg_type;

   typedef struct packed {
      logic             match;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             frame_end;
   } pix_entry_type;

   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [QUEUE_LVL_W-1:0] level;
   } queue_status_type;

endpackage

@@ rtl/core/cmbc_if.sv @@
`timescale 1ns / 1ps
// Pixel, result and register-write channel interfaces.
interface cmbc_req_if;
   logic                         valid;
   logic                         ready;
   logic [cmbc_pkg::COLOR_W-1:0] red;
   logic [cmbc_pkg::COLOR_W-1:0] green;
   logic [cmbc_pkg::COLOR_W-1:0] blue;
   logic [cmbc_pkg::POS_W-1:0]   col;
   logic [cmbc_pkg::POS_W-1:0]   row;
   logic                         frame_end;

   modport source (output valid, red, green, blue, col, row, frame_end, input ready);
   modport sink   (input valid, red, green, blue, col, row, frame_end, output ready);
endinterface

interface cmbc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [cmbc_pkg::POS_W-1:0]   centroid_col;
   logic [cmbc_pkg::POS_W-1:0]   centroid_row;
   logic [cmbc_pkg::COUNT_W-1:0] match_count;

   modport source (output valid, found, centroid_col, centroid_row, match_count,
                   input ready);
   modport sink   (input valid, found, centroid_col, centroid_row, match_count,
                   output ready);
endinterface

interface cmbc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cmbc_pkg::CSR_INDEX_W-1:0] index;
   logic [cmbc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/cmbc_queue.sv @@
`timescale 1ns / 1ps
// Short queue of classified pixels between front and back.
module cmbc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cmbc_pkg::pix_entry_type    push_data,
   input  logic                       pop,
   output cmbc_pkg::pix_entry_type    head,
   output cmbc_pkg::queue_status_type status
);

   cmbc_pkg::pix_entry_type entries_ff [cmbc_pkg::QUEUE_DEPTH];

   logic [cmbc_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cmbc_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cmbc_pkg::QUEUE_LVL_W-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + cmbc_pkg::QUEUE_LVL_W'(push)
                  - cmbc_pkg::QUEUE_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.empty = (level_ff == '0);
   assign status.full  = (level_ff == cmbc_pkg::QUEUE_LVL_W'(cmbc_pkg::QUEUE_DEPTH));

endmodule

@@ rtl/core/cmbc_front.sv @@
`timescale 1ns / 1ps
// Front end: takes pixels and classifies them against the colour mask.
module cmbc_front (
   input  logic                             clock,
   input  logic                             reset,
   cmbc_req_if.sink                         req,
   input  cmbc_pkg::cfg_type                cfg,
   input  logic [cmbc_pkg::QUEUE_LVL_W-1:0] queue_level,
   output logic                             push,
   output cmbc_pkg::pix_entry_type          push_data
);

   localparam int CREDIT_W = cmbc_pkg::QUEUE_LVL_W + 1;

   logic accept;

   // stage a: raw pixel
   logic                         a_valid_ff;
   logic [cmbc_pkg::COLOR_W-1:0] a_red_ff, a_green_ff, a_blue_ff;
   logic [cmbc_pkg::POS_W-1:0]   a_col_ff, a_row_ff;
   logic                         a_last_ff;

   logic [cmbc_pkg::S_W-1:0]   a_sum;
   logic [cmbc_pkg::LHS_W-1:0] a_red_lhs, a_green_lhs;
   logic                       a_inside;

   // stage b: sum and scaled numerators
   logic                       b_valid_ff;
   logic [cmbc_pkg::S_W-1:0]   b_sum_ff;
   logic [cmbc_pkg::LHS_W-1:0] b_red_lhs_ff, b_green_lhs_ff;
   logic [cmbc_pkg::POS_W-1:0] b_col_ff, b_row_ff;
   logic                       b_last_ff, b_inside_ff;

   logic [cmbc_pkg::S_W:0]        b_two_s;
   logic [cmbc_pkg::COLOR_W:0]    red_k, green_k;
   logic [cmbc_pkg::PROD_W-1:0]   red_rhs, green_rhs;
   logic [cmbc_pkg::S_W:0]        bright_lhs, bright_rhs;
   logic                          red_ok, green_ok, bright_ok;

   // Credit check: everything in flight must find room in the queue.
   assign req.ready = (CREDIT_W'(queue_level) + CREDIT_W'(a_valid_ff)
                       + CREDIT_W'(b_valid_ff)) < CREDIT_W'(cmbc_pkg::QUEUE_DEPTH);
   assign accept    = req.valid && req.ready;

   always_comb begin
      a_sum       = cmbc_pkg::S_W'(a_red_ff) + cmbc_pkg::S_W'(a_green_ff)
                    + cmbc_pkg::S_W'(a_blue_ff);
      a_red_lhs   = cmbc_pkg::LHS_W'({a_red_ff, 9'd0}) + cmbc_pkg::LHS_W'(a_sum);
      a_green_lhs = cmbc_pkg::LHS_W'({a_green_ff, 9'd0}) + cmbc_pkg::LHS_W'(a_sum);
      a_inside    = (cmbc_pkg::POS_CMP_W'(a_col_ff)
                     < cmbc_pkg::POS_CMP_W'(cmbc_pkg::MAX_COLS))
                    && (cmbc_pkg::POS_CMP_W'(a_row_ff)
                     < cmbc_pkg::POS_CMP_W'(cmbc_pkg::MAX_ROWS));
   end

   // round(256c/s) > t  <=>  512c + s >= 2s(t+1), saturation and s = 0 apart
   always_comb begin
      b_two_s    = {b_sum_ff, 1'b0};
      red_k      = {1'b0, cfg.red_thr} + 9'd1;
      green_k    = {1'b0, cfg.green_thr} + 9'd1;
      red_rhs    = cmbc_pkg::PROD_W'(red_k) * cmbc_pkg::PROD_W'(b_two_s);
      green_rhs  = cmbc_pkg::PROD_W'(green_k) * cmbc_pkg::PROD_W'(b_two_s);
      bright_lhs = {1'b0, b_sum_ff} + 11'd1;
      bright_rhs = (11'(cfg.bright_thr) * 11'd3) + 11'd3;

      red_ok    = (b_sum_ff != '0) && (cfg.red_thr != cmbc_pkg::THRESHOLD_TOP)
                  && (cmbc_pkg::PROD_W'(b_red_lhs_ff) >= red_rhs);
      green_ok  = (b_sum_ff == '0) || (cfg.green_thr == cmbc_pkg::THRESHOLD_TOP)
                  || (cmbc_pkg::PROD_W'(b_green_lhs_ff) < green_rhs);
      bright_ok = bright_lhs >= bright_rhs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_red_ff   <= req.red;
         a_green_ff <= req.green;
         a_blue_ff  <= req.blue;
         a_col_ff   <= req.col;
         a_row_ff   <= req.row;
         a_last_ff  <= req.frame_end;
      end
      b_sum_ff       <= a_sum;
      b_red_lhs_ff   <= a_red_lhs;
      b_green_lhs_ff <= a_green_lhs;
      b_col_ff       <= a_col_ff;
      b_row_ff       <= a_row_ff;
      b_last_ff      <= a_last_ff;
      b_inside_ff    <= a_inside;
   end

   assign push                = b_valid_ff;
   assign push_data.match     = b_inside_ff && red_ok && green_ok && bright_ok;
   assign push_data.col       = b_col_ff;
   assign push_data.row       = b_row_ff;
   assign push_data.frame_end = b_last_ff;

endmodule

@@ rtl/core/cmbc_back.sv @@
`timescale 1ns / 1ps
// Back end: accumulates matches and works out the centroid at frame end.
module cmbc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  cmbc_pkg::pix_entry_type       head,
   input  logic                          queue_empty,
   output logic                          pop,
   input  logic [cmbc_pkg::COUNT_W-1:0]  min_pixels,
   cmbc_rsp_if.source                    rsp
);

   typedef enum logic [4:0] {
      ST_RUN     = 5'b00001,
      ST_SETUP   = 5'b00010,
      ST_DIV_COL = 5'b00100,
      ST_DIV_ROW = 5'b01000,
      ST_LOAD    = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [cmbc_pkg::COUNT_W-1:0] acc_count_ff, acc_count_in;
   logic [cmbc_pkg::SUM_W-1:0]   acc_col_ff, acc_col_in;
   logic [cmbc_pkg::SUM_W-1:0]   acc_row_ff, acc_row_in;

   logic [cmbc_pkg::COUNT_W-1:0] fin_count_ff, fin_count_in;
   logic [cmbc_pkg::SUM_W-1:0]   fin_col_ff, fin_col_in;
   logic [cmbc_pkg::SUM_W-1:0]   fin_row_ff, fin_row_in;

   logic [cmbc_pkg::DIV_W-1:0]     div_quo_ff, div_quo_in;
   logic [cmbc_pkg::REM_W-1:0]     div_rem_ff, div_rem_in;
   logic [cmbc_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [cmbc_pkg::POS_W-1:0]     mean_col_ff, mean_col_in;
   logic [cmbc_pkg::POS_W-1:0]     mean_row_ff, mean_row_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [cmbc_pkg::POS_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [cmbc_pkg::POS_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [cmbc_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                         add;
   logic [cmbc_pkg::COUNT_W-1:0] new_count;
   logic [cmbc_pkg::SUM_W-1:0]   new_col, new_row;
   logic [cmbc_pkg::DIV_W-1:0]   half_count;
   logic [cmbc_pkg::REM_W-1:0]   rem_sh, rem_diff;
   logic                         rem_ge;
   logic [cmbc_pkg::DIV_W-1:0]   step_quo;
   logic [cmbc_pkg::REM_W-1:0]   step_rem;

   assign pop = (state_ff == ST_RUN) && !queue_empty;

   always_comb begin
      add       = pop && head.match && (acc_count_ff != cmbc_pkg::COUNT_MAX);
      new_count = acc_count_ff + cmbc_pkg::COUNT_W'(add);
      new_col   = acc_col_ff + (add ? cmbc_pkg::SUM_W'(head.col) : '0);
      new_row   = acc_row_ff + (add ? cmbc_pkg::SUM_W'(head.row) : '0);
   end

   // one restoring division step: a quotient bit per cycle
   always_comb begin
      half_count = cmbc_pkg::DIV_W'(fin_count_ff[cmbc_pkg::COUNT_W-1:1]);
      rem_sh     = {div_rem_ff[cmbc_pkg::REM_W-2:0], div_quo_ff[cmbc_pkg::DIV_W-1]};
      rem_ge     = rem_sh >= cmbc_pkg::REM_W'(fin_count_ff);
      rem_diff   = rem_sh - cmbc_pkg::REM_W'(fin_count_ff);
      step_rem   = rem_ge ? rem_diff : rem_sh;
      step_quo   = {div_quo_ff[cmbc_pkg::DIV_W-2:0], rem_ge};
   end

   always_comb begin
      state_in     = state_ff;
      acc_count_in = acc_count_ff;
      acc_col_in   = acc_col_ff;
      acc_row_in   = acc_row_ff;
      fin_count_in = fin_count_ff;
      fin_col_in   = fin_col_ff;
      fin_row_in   = fin_row_ff;
      div_quo_in   = div_quo_ff;
      div_rem_in   = div_rem_ff;
      div_cnt_in   = div_cnt_ff;
      mean_col_in  = mean_col_ff;
      mean_row_in  = mean_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_found_in = rsp_found_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         ST_RUN: begin
            if (pop) begin
               if (head.frame_end) begin
                  fin_count_in = new_count;
                  fin_col_in   = new_col;
                  fin_row_in   = new_row;
                  acc_count_in = '0;
                  acc_col_in   = '0;
                  acc_row_in   = '0;
                  state_in     = ST_SETUP;
               end else begin
                  acc_count_in = new_count;
                  acc_col_in   = new_col;
                  acc_row_in   = new_row;
               end
            end
         end
         ST_SETUP: begin
            div_quo_in = cmbc_pkg::DIV_W'(fin_col_ff) + half_count;
            div_rem_in = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV_COL;
         end
         ST_DIV_COL: begin
            div_quo_in = step_quo;
            div_rem_in = step_rem;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == cmbc_pkg::DIV_LAST) begin
               mean_col_in = step_quo[cmbc_pkg::POS_W-1:0];
               div_quo_in  = cmbc_pkg::DIV_W'(fin_row_ff) + half_count;
               div_rem_in  = '0;
               div_cnt_in  = '0;
               state_in    = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            div_quo_in = step_quo;
            div_rem_in = step_rem;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == cmbc_pkg::DIV_LAST) begin
               mean_row_in = step_quo[cmbc_pkg::POS_W-1:0];
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = fin_count_ff >= min_pixels;
               rsp_count_in = fin_count_ff;
               // an empty frame divides by zero: centroid reads as 0
               rsp_col_in   = (fin_count_ff == '0) ? '0 : mean_col_ff;
               rsp_row_in   = (fin_count_ff == '0) ? '0 : mean_row_ff;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         acc_count_ff <= '0;
         acc_col_ff   <= '0;
         acc_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_count_ff <= acc_count_in;
         acc_col_ff   <= acc_col_in;
         acc_row_ff   <= acc_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_count_ff <= fin_count_in;
      fin_col_ff   <= fin_col_in;
      fin_row_ff   <= fin_row_in;
      div_quo_ff   <= div_quo_in;
      div_rem_ff   <= div_rem_in;
      div_cnt_ff   <= div_cnt_in;
      mean_col_ff  <= mean_col_in;
      mean_row_ff  <= mean_row_in;
      rsp_found_ff <= rsp_found_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.centroid_col = rsp_col_ff;
   assign rsp.centroid_row = rsp_row_ff;
   assign rsp.match_count  = rsp_count_ff;

endmodule

@@ rtl/core/chroma_mask_blob_centroid_top.sv @@
`timescale 1ns / 1ps
// Chroma mask blob centroid top level. Pixels arrive one per transaction on
// req_chan and are classified by rg chromaticity and brightness in a two-stage
// front pipeline; matches are counted and their positions summed by the back
// end, which sits behind an eight-entry queue. The block takes one pixel per
// clock while the credit check finds room in the queue. On the pixel marked
// frame_end the back end runs a shared restoring divider, one quotient bit per
// cycle, first for the column then for the row mean, and then loads the result
// on rsp_chan. The front keeps taking pixels during that time until eight are
// held in the queue and its two stages together. Registers are written on
// csr_chan, which is always ready; writes to an unknown index are dropped.
`include "chroma_mask_blob_centroid_top_defines.svh"

module chroma_mask_blob_centroid_top (
   input  logic        clock,
   input  logic        reset,
   cmbc_req_if.sink    req_chan,
   cmbc_rsp_if.source  rsp_chan,
   cmbc_csr_if.sink    csr_chan
);

   cmbc_pkg::cfg_type cfg_ff, cfg_in;

   logic                       q_push;
   logic                       q_pop;
   cmbc_pkg::pix_entry_type    q_push_data;
   cmbc_pkg::pix_entry_type    q_head;
   cmbc_pkg::queue_status_type q_status;

   logic                       rsp_empty_frame;
   logic                       rsp_centroid_zero;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            cmbc_pkg::CSR_RED_THRESHOLD:
               cfg_in.red_thr = csr_chan.data[cmbc_pkg::COLOR_W-1:0];
            cmbc_pkg::CSR_GREEN_THRESHOLD:
               cfg_in.green_thr = csr_chan.data[cmbc_pkg::COLOR_W-1:0];
            cmbc_pkg::CSR_BRIGHTNESS_THRESHOLD:
               cfg_in.bright_thr = csr_chan.data[cmbc_pkg::COLOR_W-1:0];
            cmbc_pkg::CSR_MIN_PIXELS:
               cfg_in.min_pixels = csr_chan.data[cmbc_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_thr    <= '0;
         cfg_ff.green_thr  <= '0;
         cfg_ff.bright_thr <= '0;
         cfg_ff.min_pixels <= cmbc_pkg::MIN_PIXELS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cmbc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .cfg         (cfg_ff),
      .queue_level (q_status.level),
      .push        (q_push),
      .push_data   (q_push_data)
   );

   cmbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   cmbc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .queue_empty (q_status.empty),
      .pop         (q_pop),
      .min_pixels  (cfg_ff.min_pixels),
      .rsp         (rsp_chan)
   );

   assign rsp_empty_frame   = rsp_chan.valid && (rsp_chan.match_count == '0);
   assign rsp_centroid_zero = (rsp_chan.centroid_col == '0)
                              && (rsp_chan.centroid_row == '0);

   // credit accounting must keep the queue from overflowing
   `CMBC_ASSERT_IMPLY(a_push_has_room, clock, reset, q_push, !q_status.full)
   `CMBC_ASSERT_IMPLY(a_pop_not_empty, clock, reset, q_pop, !q_status.empty)
   `CMBC_ASSERT_NEXT(a_push_fills, clock, reset, q_push && !q_pop, !q_status.empty)
   `CMBC_ASSERT_IMPLY(a_empty_frame_zero, clock, reset, rsp_empty_frame, rsp_centroid_zero)

endmodule
